FILE: sv/rnet_pkg.sv
// Package for the spatial index node entry table.
// Holds the transaction payload types, operation and status codes and the
// command and status structs shared by the controller and the datapath.
package rnet_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam int COUNT_OUT_W = 9;

  typedef struct packed {
    logic [1:0]          opcode;
    logic signed [31:0]  rect_min_x;
    logic signed [31:0]  rect_min_y;
    logic signed [31:0]  rect_max_x;
    logic signed [31:0]  rect_max_y;
    logic [30:0]         entry_tag;
    logic [7:0]          slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   found;
    logic [COUNT_OUT_W-1:0] count;
    logic signed [31:0]     bound_min_x;
    logic signed [31:0]     bound_min_y;
    logic signed [31:0]     bound_max_x;
    logic signed [31:0]     bound_max_y;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic [30:0]        tag;
  } entry_t;

  typedef struct packed {
    logic load;
    logic judge;
    logic add_commit;
    logic rd_slot;
    logic hold_del;
    logic rd_last;
    logic move;
    logic clear_bounds;
    logic scan_start;
    logic scan_rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       slot_bad;
    logic       touch;
    logic       scan_last;
    logic       out_busy;
  } sts_t;

endpackage

FILE: sv/rnet_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module rnet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/rnet_ctrl.sv
// Controller state machine for the node entry table.
// Depends on rnet_pkg; drives commands to rnet_datapath from its status.
module rnet_ctrl
  import rnet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_DISPATCH = 8'b00000010,
    S_DEL_A    = 8'b00000100,
    S_DEL_B    = 8'b00001000,
    S_DEL_C    = 8'b00010000,
    S_SCAN     = 8'b00100000,
    S_DRAIN    = 8'b01000000,
    S_DONE     = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.judge = 1'b1;
        state_next = S_DONE;
        case (sts.op)
          OP_ADD: begin
            if (!sts.full) begin
              cmd.add_commit = 1'b1;
            end
          end
          OP_FIND: begin
            if (!sts.empty) begin
              cmd.scan_start = 1'b1;
              state_next = S_SCAN;
            end
          end
          OP_DELETE: begin
            if (!sts.empty && !sts.slot_bad) begin
              cmd.rd_slot = 1'b1;
              state_next = S_DEL_A;
            end
          end
          default: begin
          end
        endcase
      end
      S_DEL_A: begin
        cmd.hold_del = 1'b1;
        cmd.rd_last = 1'b1;
        state_next = S_DEL_B;
      end
      S_DEL_B: begin
        cmd.move = 1'b1;
        state_next = S_DEL_C;
      end
      S_DEL_C: begin
        if (sts.empty) begin
          cmd.clear_bounds = 1'b1;
          state_next = S_DONE;
        end else if (sts.touch) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_scan_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !sts.empty)
    else $error("Scan running over an empty table.");
  a_emit_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> in_ready)
    else $error("Controller not idle after delivering a result.");
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DISPATCH))
    else $error("Accepted transaction not dispatched.");
`endif

endmodule

FILE: sv/rnet_datapath.sv
// Datapath of the node entry table: request register, entry RAM, count,
// bounds, scan pipeline and output register. Depends on rnet_pkg and rnet_ram.
module rnet_datapath
  import rnet_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  input  req_t in_data,
  output rsp_t out_data,
  output logic out_valid,
  input  logic out_ready,
  input  cmd_t cmd,
  output sts_t sts
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  req_t               req;
  entry_t             del;
  entry_t             rd_ent;
  entry_t             new_ent;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic               pend;
  logic               seed;
  logic               found;
  logic [1:0]         res_status;
  logic signed [31:0] bnd_min_x, bnd_min_y, bnd_max_x, bnd_max_y;

  logic               we;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  logic [$bits(entry_t)-1:0] wr_data;
  logic [$bits(entry_t)-1:0] rd_data;
  logic               match;

  always_comb begin
    new_ent.min_x = req.rect_min_x;
    new_ent.min_y = req.rect_min_y;
    new_ent.max_x = req.rect_max_x;
    new_ent.max_y = req.rect_max_y;
    new_ent.tag   = req.entry_tag;
    rd_ent = entry_t'(rd_data);
  end

  always_comb begin
    we = cmd.add_commit | cmd.move;
    wr_addr = cmd.move ? req.slot_index[IDX_W-1:0] : count[IDX_W-1:0];
    wr_data = cmd.move ? rd_data : new_ent;
    if (cmd.rd_slot) begin
      rd_addr = req.slot_index[IDX_W-1:0];
    end else if (cmd.rd_last) begin
      rd_addr = IDX_W'(count - CNT_W'(1));
    end else begin
      rd_addr = idx;
    end
  end

  rnet_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    match = (rd_ent.tag == req.entry_tag) && (rd_ent.min_x == req.rect_min_x) &&
            (rd_ent.min_y == req.rect_min_y) && (rd_ent.max_x == req.rect_max_x) &&
            (rd_ent.max_y == req.rect_max_y);
    sts.op        = req.opcode;
    sts.full      = (count == CNT_W'(MAX_ENTRIES));
    sts.empty     = (count == '0);
    sts.slot_bad  = ({1'b0, req.slot_index} >= COUNT_OUT_W'(count));
    sts.touch     = (bnd_min_x == del.min_x) || (bnd_min_y == del.min_y) ||
                    (bnd_max_x == del.max_x) || (bnd_max_y == del.max_y);
    sts.scan_last = ((CNT_W'(idx) + CNT_W'(1)) == count);
    sts.out_busy  = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
    if (cmd.hold_del) begin
      del <= rd_ent;
    end
    if (cmd.judge) begin
      if ((req.opcode == OP_ADD) && sts.full) begin
        res_status <= ST_FULL;
      end else if ((req.opcode == OP_DELETE) && sts.empty) begin
        res_status <= ST_EMPTY;
      end else if ((req.opcode == OP_DELETE) && sts.slot_bad) begin
        res_status <= ST_RANGE;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.emit) begin
      out_data.status      <= res_status;
      out_data.found       <= found;
      out_data.count       <= COUNT_OUT_W'(count);
      out_data.bound_min_x <= bnd_min_x;
      out_data.bound_min_y <= bnd_min_y;
      out_data.bound_max_x <= bnd_max_x;
      out_data.bound_max_y <= bnd_max_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bnd_min_x <= '0;
      bnd_min_y <= '0;
      bnd_max_x <= '0;
      bnd_max_y <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      seed      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.scan_rd;
      if (cmd.judge) begin
        found <= 1'b0;
      end
      if (cmd.add_commit) begin
        count <= count + CNT_W'(1);
        if (count == '0) begin
          bnd_min_x <= req.rect_min_x;
          bnd_min_y <= req.rect_min_y;
          bnd_max_x <= req.rect_max_x;
          bnd_max_y <= req.rect_max_y;
        end else begin
          if (req.rect_min_x < bnd_min_x) bnd_min_x <= req.rect_min_x;
          if (req.rect_min_y < bnd_min_y) bnd_min_y <= req.rect_min_y;
          if (req.rect_max_x > bnd_max_x) bnd_max_x <= req.rect_max_x;
          if (req.rect_max_y > bnd_max_y) bnd_max_y <= req.rect_max_y;
        end
      end
      if (cmd.move) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.clear_bounds) begin
        bnd_min_x <= '0;
        bnd_min_y <= '0;
        bnd_max_x <= '0;
        bnd_max_y <= '0;
      end
      if (cmd.scan_start) begin
        idx  <= '0;
        seed <= 1'b1;
      end
      if (cmd.scan_rd) begin
        idx <= idx + IDX_W'(1);
      end
      if (pend) begin
        if (req.opcode == OP_FIND) begin
          found <= found | match;
        end else if (seed) begin
          seed      <= 1'b0;
          bnd_min_x <= rd_ent.min_x;
          bnd_min_y <= rd_ent.min_y;
          bnd_max_x <= rd_ent.max_x;
          bnd_max_y <= rd_ent.max_y;
        end else begin
          if (rd_ent.min_x < bnd_min_x) bnd_min_x <= rd_ent.min_x;
          if (rd_ent.min_y < bnd_min_y) bnd_min_y <= rd_ent.min_y;
          if (rd_ent.max_x > bnd_max_x) bnd_max_x <= rd_ent.max_x;
          if (rd_ent.max_y > bnd_max_y) bnd_max_y <= rd_ent.max_y;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("Entry count above table size.");
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    cmd.add_commit |=> (count == $past(count) + CNT_W'(1)))
    else $error("Add did not increment the count.");
  a_move_count: assert property (@(posedge clk) disable iff (rst)
    cmd.move |=> (count == $past(count) - CNT_W'(1)))
    else $error("Delete did not decrement the count.");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("Result overwrote an undelivered transaction.");
  a_add_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.add_commit |-> !sts.full)
    else $error("Add committed into a full table.");
`endif

endmodule

FILE: sv/rtree_node_entry_table.sv
// From accepted transaction to result valid: add, rejected or no-op go from dispatch
// straight to the result; find scans every held entry first (not on an empty table);
// delete moves the last entry into the slot, plus a bounds rebuild when bounds are touched.
// Find and rebuild scan the entry RAM at one entry per cycle through its read port.
// One transaction at a time; a new one is taken the cycle after the result is registered.
// Reset is synchronous: count and bounds clear at once, the entry RAM is not cleared.
module rtree_node_entry_table
  import rnet_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  cmd_t cmd;
  sts_t sts;

  rnet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rnet_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
